[hdl/dtr_pkg.sv]
package dtr_pkg;

  // Cycle count wraps to zero on reaching this value.
  localparam int unsigned CYCLES_PER_SECOND = 4194304;
  localparam int unsigned CNT_W = $clog2(CYCLES_PER_SECOND);

  localparam int unsigned MASK_W = 13;
  localparam int unsigned AND_W = (CNT_W > MASK_W) ? CNT_W : MASK_W;

  localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
  localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
  localparam logic [15:0] ADDR_MODULO  = 16'hFF06;
  localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

  localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(4096);
  localparam logic [MASK_W-1:0] MASK_1024  = MASK_W'(1024 - 1);
  localparam logic [MASK_W-1:0] MASK_16    = MASK_W'(16 - 1);
  localparam logic [MASK_W-1:0] MASK_64    = MASK_W'(64 - 1);
  localparam logic [MASK_W-1:0] MASK_256   = MASK_W'(256 - 1);

  localparam int unsigned CTRL_ENABLE_BIT = 2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    PRESCALE_1024 = 2'd0,
    PRESCALE_16   = 2'd1,
    PRESCALE_64   = 2'd2,
    PRESCALE_256  = 2'd3
  } prescale_t;

  typedef struct packed {
    command_t    command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       overflow;
  } res_item_t;

endpackage

[hdl/divider_timer_with_reload.sv]
// Memory-mapped divider and counter timer. Each request is a tick, a bus read or a bus
// write; every request produces exactly one result in the cycle after it is accepted. A new
// request is taken every clock as long as the result register is empty or being drained
// in the same cycle, so the sustained rate is one request per cycle; the only thing that
// holds the input back is a stalled result (cmd_stall follows res_stall while a result
// waits). Registers sit at FF04 (divider, cleared by any write), FF05 (counter), FF06
// (reload value) and FF07 (control: bit 2 enable, bits 1:0 prescale 1024/16/64/256 ticks).
module divider_timer_with_reload import dtr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  logic [CNT_W-1:0]  cycle_count, cycle_count_next;
  logic [7:0]        divider, divider_next;
  logic [7:0]        counter, counter_next;
  logic [7:0]        modulo, modulo_next;
  logic [7:0]        control, control_next;
  logic              enabled, enabled_next;
  logic [MASK_W-1:0] prescale_mask, prescale_mask_next;
  res_item_t         res_next;

  logic              accept;
  logic [CNT_W:0]    count_inc;
  logic [AND_W-1:0]  masked;
  logic [7:0]        counter_inc;

  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    cycle_count_next   = cycle_count;
    divider_next       = divider;
    counter_next       = counter;
    modulo_next        = modulo;
    control_next       = control;
    enabled_next       = enabled;
    prescale_mask_next = prescale_mask;
    res_next           = '0;

    count_inc   = {1'b0, cycle_count} + (CNT_W+1)'(1);
    masked      = '0;
    counter_inc = counter + 8'd1;

    case (cmd.command)
      CMD_TICK: begin
        if (count_inc >= (CNT_W+1)'(CYCLES_PER_SECOND)) begin
          cycle_count_next = '0;
        end else begin
          cycle_count_next = count_inc[CNT_W-1:0];
        end
        if (cycle_count_next[7:0] == 8'd0) begin
          divider_next = divider + 8'd1;
        end
        masked = AND_W'(cycle_count_next) & AND_W'(prescale_mask);
        if (enabled && masked == '0) begin
          // reload on wrap and raise the interrupt
          if (counter_inc == 8'd0) begin
            counter_next      = modulo;
            res_next.overflow = 1'b1;
          end else begin
            counter_next = counter_inc;
          end
        end
      end
      CMD_READ: begin
        case (cmd.address)
          ADDR_DIVIDER: res_next.read_data = divider;
          ADDR_COUNTER: res_next.read_data = counter;
          ADDR_MODULO:  res_next.read_data = modulo;
          ADDR_CONTROL: res_next.read_data = control;
          default:      res_next.read_data = 8'd0;
        endcase
      end
      CMD_WRITE: begin
        case (cmd.address)
          ADDR_DIVIDER: divider_next = 8'd0;
          ADDR_COUNTER: counter_next = cmd.write_data;
          ADDR_MODULO:  modulo_next  = cmd.write_data;
          ADDR_CONTROL: begin
            control_next = cmd.write_data;
            enabled_next = cmd.write_data[CTRL_ENABLE_BIT];
            case (prescale_t'(cmd.write_data[1:0]))
              PRESCALE_1024: prescale_mask_next = MASK_1024;
              PRESCALE_16:   prescale_mask_next = MASK_16;
              PRESCALE_64:   prescale_mask_next = MASK_64;
              PRESCALE_256:  prescale_mask_next = MASK_256;
              default:       prescale_mask_next = MASK_1024;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_count   <= '0;
      divider       <= '0;
      counter       <= '0;
      modulo        <= '0;
      control       <= '0;
      enabled       <= 1'b0;
      prescale_mask <= MASK_RESET;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        cycle_count   <= cycle_count_next;
        divider       <= divider_next;
        counter       <= counter_next;
        modulo        <= modulo_next;
        control       <= control_next;
        enabled       <= enabled_next;
        prescale_mask <= prescale_mask_next;
        res_valid     <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // hold the result while it is stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cycle_count} < (CNT_W+1)'(CYCLES_PER_SECOND))
    else $error("cycle count out of range");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted request produced no result");

  a_no_overflow_when_disabled: assert property (@(posedge clk) disable iff (rst)
    (accept && !enabled) |=> !res.overflow)
    else $error("overflow raised while timer disabled");

  a_reload_on_overflow: assert property (@(posedge clk) disable iff (rst)
    (accept && res_next.overflow) |=> (counter == modulo))
    else $error("counter not reloaded on overflow");

endmodule
